[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define ETFI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ETFI_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/etfi_pkg.sv]
// Shared constants, types and helpers of the escape-time fractal iterator.
`default_nettype none

package etfi_pkg;

    localparam int FRAC_BITS   = 28;
    localparam int COUNT_WIDTH = 16;
    localparam int FIELD_W     = 31;
    localparam int Z_W         = 32;
    localparam int PROD_W      = 2 * Z_W;
    localparam int SQ_W        = PROD_W - 1 - FRAC_BITS;
    localparam int XY_W        = PROD_W - FRAC_BITS + 1;
    localparam int MAG_W       = 36;
    localparam int SUM_W       = ((SQ_W > XY_W) ? SQ_W : XY_W) + 3;
    localparam int DATA_W      = 32;
    localparam int PADDR_W     = 4;
    localparam int REG_IDX_W   = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_C_REAL   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_C_IMAG   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_ESC_LIM  = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_MAX_ITER = 2'd3;

    localparam logic [FIELD_W-1:0]     ESC_LIM_RESET  = 31'h4000_0000;
    localparam logic [COUNT_WIDTH-1:0] MAX_ITER_RESET = COUNT_WIDTH'(1000);

    typedef struct packed {
        logic load;
        logic mul;
        logic step;
        logic out_load;
    } etfi_cmd_t;

    typedef struct packed {
        logic esc;
        logic cap_hit;
        logic out_free;
    } etfi_status_t;

    function automatic logic signed [Z_W-1:0] sat_z(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-Z_W:0] hi;
        logic signed [Z_W-1:0] r;
        hi = v[SUM_W-1:Z_W-1];
        if ((&hi) || !(|hi))
            r = v[Z_W-1:0];
        else if (v[SUM_W-1])
            r = {1'b1, {(Z_W-1){1'b0}}};
        else
            r = {1'b0, {(Z_W-1){1'b1}}};
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/etfi_regs.sv]
// APB configuration registers: c, escape limit, iteration cap.
`default_nettype none

module etfi_regs (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [etfi_pkg::PADDR_W-1:0]          paddr,
    input  wire logic [etfi_pkg::DATA_W-1:0]           pwdata,
    output logic      [etfi_pkg::DATA_W-1:0]           prdata,
    output logic                                       pready,
    output logic signed [etfi_pkg::FIELD_W-1:0]        c_real,
    output logic signed [etfi_pkg::FIELD_W-1:0]        c_imag,
    output logic      [etfi_pkg::FIELD_W-1:0]          escape_limit,
    output logic      [etfi_pkg::COUNT_WIDTH-1:0]      max_iterations
);
    import etfi_pkg::*;

    logic [FIELD_W-1:0]     c_real_reg;
    logic [FIELD_W-1:0]     c_imag_reg;
    logic [FIELD_W-1:0]     esc_lim_reg;
    logic [COUNT_WIDTH-1:0] max_iter_reg;
    logic                   wr_en;
    logic [REG_IDX_W-1:0]   idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_real_reg   <= '0;
            c_imag_reg   <= '0;
            esc_lim_reg  <= ESC_LIM_RESET;
            max_iter_reg <= MAX_ITER_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_C_REAL:   c_real_reg   <= pwdata[FIELD_W-1:0];
                REG_C_IMAG:   c_imag_reg   <= pwdata[FIELD_W-1:0];
                REG_ESC_LIM:  esc_lim_reg  <= pwdata[FIELD_W-1:0];
                REG_MAX_ITER: max_iter_reg <= pwdata[COUNT_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_C_REAL:   prdata = DATA_W'(c_real_reg);
            REG_C_IMAG:   prdata = DATA_W'(c_imag_reg);
            REG_ESC_LIM:  prdata = DATA_W'(esc_lim_reg);
            REG_MAX_ITER: prdata = DATA_W'(max_iter_reg);
            default:      prdata = '0;
        endcase
    end

    assign c_real         = c_real_reg;
    assign c_imag         = c_imag_reg;
    assign escape_limit   = esc_lim_reg;
    assign max_iterations = max_iter_reg;

endmodule

`default_nettype wire

[hw/rtl/etfi_ctrl.sv]
// Iteration sequencer: load, multiply, evaluate, deliver.
`default_nettype none

module etfi_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire etfi_pkg::etfi_status_t status,
    output etfi_pkg::etfi_cmd_t         cmd
);
    import etfi_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_EVAL = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       finish;

    assign in_stall = (state_reg != ST_IDLE);
    assign finish   = status.esc || status.cap_hit;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (!finish)
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_MUL;
                end
                else if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

[hw/rtl/etfi_datapath.sv]
// z registers, squaring products, update, counter and result register.
`default_nettype none

module etfi_datapath (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire etfi_pkg::etfi_cmd_t                  cmd,
    output etfi_pkg::etfi_status_t                    status,
    input  wire logic signed [etfi_pkg::FIELD_W-1:0]  start_re,
    input  wire logic signed [etfi_pkg::FIELD_W-1:0]  start_im,
    input  wire logic signed [etfi_pkg::FIELD_W-1:0]  c_real,
    input  wire logic signed [etfi_pkg::FIELD_W-1:0]  c_imag,
    input  wire logic [etfi_pkg::FIELD_W-1:0]         escape_limit,
    input  wire logic [etfi_pkg::COUNT_WIDTH-1:0]     max_iterations,
    input  wire logic                                 out_stall,
    output logic                                      out_valid,
    output logic                                      escaped,
    output logic [etfi_pkg::COUNT_WIDTH-1:0]          iterations,
    output logic [etfi_pkg::MAG_W-1:0]                final_mag_sq
);
    import etfi_pkg::*;

    logic signed [Z_W-1:0]    z_re_reg;
    logic signed [Z_W-1:0]    z_im_reg;
    logic [SQ_W-1:0]          xx_reg;
    logic [SQ_W-1:0]          yy_reg;
    logic signed [XY_W-1:0]   xy_reg;
    logic [COUNT_WIDTH-1:0]   cnt_reg;
    logic                     out_valid_reg;
    logic                     escaped_reg;
    logic [COUNT_WIDTH-1:0]   iter_reg;
    logic [MAG_W-1:0]         mag_reg;

    logic signed [PROD_W-1:0] p_rr;
    logic signed [PROD_W-1:0] p_ii;
    logic signed [PROD_W-1:0] p_ri;
    logic [MAG_W-1:0]         mag;
    logic signed [SUM_W-1:0]  re_sum;
    logic signed [SUM_W-1:0]  im_sum;
    logic [COUNT_WIDTH-1:0]   cnt_inc;
    logic [COUNT_WIDTH-1:0]   cap;
    logic                     esc;

    assign p_rr = z_re_reg * z_re_reg;
    assign p_ii = z_im_reg * z_im_reg;
    assign p_ri = z_re_reg * z_im_reg;

    assign mag    = MAG_W'(xx_reg) + MAG_W'(yy_reg);
    assign esc    = (mag >= MAG_W'(escape_limit));
    assign re_sum = SUM_W'($signed({1'b0, xx_reg})) - SUM_W'($signed({1'b0, yy_reg}))
                  + SUM_W'(c_real);
    assign im_sum = SUM_W'(xy_reg) + SUM_W'(c_imag);

    assign cnt_inc = cnt_reg + 1'b1;
    assign cap     = (max_iterations == '0) ? COUNT_WIDTH'(1) : max_iterations;

    assign status.esc      = esc;
    assign status.cap_hit  = (cnt_inc >= cap);
    assign status.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            z_re_reg <= Z_W'(start_re);
            z_im_reg <= Z_W'(start_im);
            cnt_reg  <= '0;
        end
        else if (cmd.step)
        begin
            z_re_reg <= sat_z(re_sum);
            z_im_reg <= sat_z(im_sum);
            cnt_reg  <= cnt_inc;
        end
        if (cmd.mul)
        begin
            xx_reg <= SQ_W'(p_rr >> FRAC_BITS);
            yy_reg <= SQ_W'(p_ii >> FRAC_BITS);
            xy_reg <= XY_W'(p_ri >>> (FRAC_BITS - 1));
        end
        if (cmd.out_load)
        begin
            escaped_reg <= esc;
            iter_reg    <= esc ? cnt_reg : cnt_inc;
            mag_reg     <= esc ? mag : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign out_valid    = out_valid_reg;
    assign escaped      = escaped_reg;
    assign iterations   = iter_reg;
    assign final_mag_sq = mag_reg;

endmodule

`default_nettype wire

[hw/rtl/escape_time_fractal_iterator.sv]
// Top level of the escape-time fractal iterator.
// One start point is worked at a time. After a point is taken, each
// iteration of z = z^2 + c first registers the squaring products, then
// does the escape compare and the z update. The result sits in an output
// register, so the next point is taken while the last result still waits.
`default_nettype none

module escape_time_fractal_iterator (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [etfi_pkg::PADDR_W-1:0]         paddr,
    input  wire logic [etfi_pkg::DATA_W-1:0]          pwdata,
    output logic      [etfi_pkg::DATA_W-1:0]          prdata,
    output logic                                      pready,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic signed [etfi_pkg::FIELD_W-1:0]  start_re,
    input  wire logic signed [etfi_pkg::FIELD_W-1:0]  start_im,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic                                      escaped,
    output logic [etfi_pkg::COUNT_WIDTH-1:0]          iterations,
    output logic [etfi_pkg::MAG_W-1:0]                final_mag_sq
);
    import etfi_pkg::*;

    logic signed [FIELD_W-1:0] c_real;
    logic signed [FIELD_W-1:0] c_imag;
    logic [FIELD_W-1:0]        escape_limit;
    logic [COUNT_WIDTH-1:0]    max_iterations;
    etfi_cmd_t                 cmd;
    etfi_status_t              status;

    etfi_regs u_regs (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .c_real         (c_real),
        .c_imag         (c_imag),
        .escape_limit   (escape_limit),
        .max_iterations (max_iterations)
    );

    etfi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    etfi_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .start_re       (start_re),
        .start_im       (start_im),
        .c_real         (c_real),
        .c_imag         (c_imag),
        .escape_limit   (escape_limit),
        .max_iterations (max_iterations),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .escaped        (escaped),
        .iterations     (iterations),
        .final_mag_sq   (final_mag_sq)
    );

endmodule

`default_nettype wire

[hw/rtl/etfi_checker.sv]
// Port-level checks of the escape-time fractal iterator, bound to the top.
`default_nettype none
`include "assert_macros.svh"

module etfi_checker (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    input  wire logic                                 in_stall,
    input  wire logic                                 out_valid,
    input  wire logic                                 out_stall,
    input  wire logic                                 escaped,
    input  wire logic [etfi_pkg::COUNT_WIDTH-1:0]     iterations,
    input  wire logic [etfi_pkg::MAG_W-1:0]           final_mag_sq
);

    // a taken point keeps the block busy for at least the next cycle
    `ETFI_ASSERT(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "not busy after beat")

    `ETFI_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped")

    `ETFI_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(escaped) && $stable(iterations) && $stable(final_mag_sq), "stalled result changed")

    // non-escaping points report zero magnitude
    `ETFI_ASSERT(a_no_esc_mag, out_valid && !escaped |-> final_mag_sq == '0, "magnitude on non-escape")

    `ETFI_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> !out_valid && !in_stall, "not idle in reset")

endmodule

bind escape_time_fractal_iterator etfi_checker u_etfi_checker (.*);

`default_nettype wire
